// ===== sv/hts_pkg.sv =====
// Shared constants, character codes, helper functions and control structs
// for the HTML text stripper. No dependencies.
package hts_pkg;

    localparam int          TAG_HOLD_DEF = 32;
    localparam logic [15:0] CAP_RESET    = 16'd4096;

    localparam logic [1:0] MODE_TEXT   = 2'd0;
    localparam logic [1:0] MODE_TAG    = 2'd1;
    localparam logic [1:0] MODE_ENTITY = 2'd2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // characters of "&nbsp;" by position
    function automatic logic [7:0] entity_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_AMP;
            3'd1:    c = CH_N;
            3'd2:    c = CH_B;
            3'd3:    c = CH_S;
            3'd4:    c = CH_P;
            3'd5:    c = CH_SEMI;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= CH_LA) && (l <= CH_LZ);
    endfunction

    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic plan_busy;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/hts_in_if.sv =====
// Input channel of the HTML text stripper: one raw byte per item.
// Depends on nothing.
interface hts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

// ===== sv/hts_out_if.sv =====
// Output channel of the HTML text stripper: one result per item.
// Depends on nothing.
interface hts_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        buffer_full;
    logic [15:0] chunk_copied;
    logic        last;

    modport source (output valid, output out_byte, output out_valid, output buffer_full,
                    output chunk_copied, output last, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input buffer_full,
                    input chunk_copied, input last, output ready);
endinterface

// ===== sv/hts_ctrl.sv =====
// Controller of the HTML text stripper: idle/run sequencing of results.
// Depends on hts_pkg.
module hts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hts_pkg::t_sts i_sts,
    output hts_pkg::t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd.emit   = (r_state == ST_RUN) && i_sts.out_free;
        o_in_ready   = (r_state == ST_IDLE) || (o_cmd.emit && i_sts.emit_last);
        o_cmd.accept = i_in_valid && o_in_ready;
        n_state      = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.plan_busy) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.emit && i_sts.emit_last) begin
                    n_state = (o_cmd.accept && i_sts.plan_busy) ? ST_RUN : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/hts_dpath.sv =====
// Datapath of the HTML text stripper: filter state, tag hold memory,
// per-item result plan, fill counters and output register. Depends on hts_pkg.
module hts_dpath #(
    parameter int TAG_HOLD = hts_pkg::TAG_HOLD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic [7:0]    i_in_byte,
    input  logic          i_chunk_end,
    input  hts_pkg::t_cmd i_cmd,
    output hts_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_out_kept,
    output logic          o_buffer_full,
    output logic [15:0]   o_chunk_copied,
    output logic          o_last
);

    localparam int HC_W  = $clog2(TAG_HOLD + 1);
    localparam int AW    = $clog2(TAG_HOLD);
    localparam int CNT_W = $clog2(TAG_HOLD + 3);

    logic [7:0]        mem [TAG_HOLD];
    logic [7:0]        r_rd_data;

    logic [1:0]        r_mode;
    logic [HC_W-1:0]   r_hc;
    logic [7:0]        r_prev;
    logic [15:0]       r_cap;
    logic [15:0]       r_fill;
    logic [15:0]       r_ck;

    logic [7:0]        r_b;
    logic              r_end;
    logic [CNT_W-1:0]  r_ca;
    logic              r_srca_tag;
    logic              r_text;
    logic              r_srcb_tag;
    logic [CNT_W-1:0]  r_offb;
    logic [CNT_W-1:0]  r_total;
    logic              r_empty;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  n_pos;

    logic              r_ov;
    logic [7:0]        r_obyte;
    logic              r_okept;
    logic              r_ofull;
    logic [15:0]       r_ocopied;
    logic              r_olast;

    logic [1:0]        mode_mid;
    logic [HC_W-1:0]   hc_mid;
    logic [1:0]        n_mode;
    logic [HC_W-1:0]   n_hc;
    logic              text_run;
    logic              txt_keep;
    logic              we;
    logic [CNT_W-1:0]  ca;
    logic              srca_tag;
    logic [CNT_W-1:0]  cb;
    logic              srcb_tag;
    logic [CNT_W-1:0]  offb;
    logic [CNT_W-1:0]  sum;
    logic              empty;
    logic [CNT_W-1:0]  total;

    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic              we_acc;

    logic [CNT_W-1:0]  idxb;
    logic [7:0]        bsel;
    logic              emit_last;
    logic              keep_ok;
    logic [15:0]       ck_new;

    // plan of the results that the offered item causes
    always_comb begin
        mode_mid = r_mode;
        hc_mid   = r_hc;
        text_run = 1'b0;
        txt_keep = 1'b0;
        we       = 1'b0;
        ca       = '0;
        srca_tag = 1'b0;
        cb       = '0;
        srcb_tag = 1'b0;
        case (r_mode)
            hts_pkg::MODE_TAG: begin
                if (i_in_byte == hts_pkg::CH_GT) begin
                    mode_mid = hts_pkg::MODE_TEXT;
                    hc_mid   = '0;
                end else if (i_in_byte[7] || (r_hc >= HC_W'(TAG_HOLD))) begin
                    ca       = CNT_W'(r_hc);
                    srca_tag = 1'b1;
                    text_run = 1'b1;
                end else begin
                    we     = 1'b1;
                    hc_mid = r_hc + HC_W'(1);
                end
            end
            hts_pkg::MODE_ENTITY: begin
                if ((r_hc == '0) || (r_hc > HC_W'(5))) begin
                    ca       = CNT_W'(r_hc);
                    text_run = 1'b1;
                end else if (i_in_byte == hts_pkg::entity_char(r_hc[2:0])) begin
                    if (r_hc == HC_W'(5)) begin
                        mode_mid = hts_pkg::MODE_TEXT;
                        hc_mid   = '0;
                    end else begin
                        hc_mid = r_hc + HC_W'(1);
                    end
                end else begin
                    ca       = CNT_W'(r_hc);
                    text_run = 1'b1;
                end
            end
            default: text_run = 1'b1;
        endcase

        if (text_run) begin
            mode_mid = hts_pkg::MODE_TEXT;
            hc_mid   = '0;
            if (i_in_byte == hts_pkg::CH_LT) begin
                mode_mid = hts_pkg::MODE_TAG;
            end else if (i_in_byte == hts_pkg::CH_AMP) begin
                mode_mid = hts_pkg::MODE_ENTITY;
                hc_mid   = HC_W'(1);
            end else if ((i_in_byte == hts_pkg::CH_CR) || (i_in_byte == hts_pkg::CH_LF)) begin
                txt_keep = 1'b0;
            end else if ((i_in_byte == hts_pkg::CH_SPACE) || (i_in_byte == hts_pkg::CH_TAB)) begin
                txt_keep = hts_pkg::is_letter(r_prev);
            end else begin
                txt_keep = 1'b1;
            end
        end

        n_mode = mode_mid;
        n_hc   = hc_mid;
        if (i_chunk_end) begin
            if (mode_mid == hts_pkg::MODE_TAG) begin
                cb       = CNT_W'(hc_mid);
                srcb_tag = 1'b1;
            end else if (mode_mid == hts_pkg::MODE_ENTITY) begin
                cb = CNT_W'(hc_mid);
            end
            n_mode = hts_pkg::MODE_TEXT;
            n_hc   = '0;
        end

        offb  = ca + CNT_W'(txt_keep);
        sum   = offb + cb;
        empty = i_chunk_end && (sum == '0);
        total = empty ? CNT_W'(1) : sum;
    end

    // result selection for the current position
    always_comb begin
        idxb = r_pos - r_offb;
        if (r_pos < r_ca) begin
            bsel = r_srca_tag ? r_rd_data : hts_pkg::entity_char(r_pos[2:0]);
        end else if (r_text && (r_pos == r_ca)) begin
            bsel = r_b;
        end else begin
            bsel = r_srcb_tag ? r_rd_data : hts_pkg::entity_char(idxb[2:0]);
        end
        emit_last = (r_pos == (r_total - CNT_W'(1)));
        keep_ok   = !r_empty && (r_fill < r_cap);
        ck_new    = r_ck + 16'(keep_ok);
    end

    always_comb begin
        if (i_cmd.accept) begin
            n_pos = '0;
        end else if (i_cmd.emit) begin
            n_pos = r_pos + CNT_W'(1);
        end else begin
            n_pos = r_pos;
        end
        waddr  = r_hc[AW-1:0];
        raddr  = n_pos[AW-1:0];
        we_acc = i_cmd.accept && we;
    end

    assign o_sts.plan_busy = (total != '0);
    assign o_sts.emit_last = emit_last;
    assign o_sts.out_free  = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (we_acc) begin
            mem[waddr] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_acc && (waddr == raddr)) begin
            r_rd_data <= i_in_byte;
        end else begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hts_pkg::MODE_TEXT;
            r_hc   <= '0;
            r_prev <= '0;
            r_cap  <= hts_pkg::CAP_RESET;
            r_fill <= '0;
            r_ck   <= '0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_mode <= n_mode;
                r_hc   <= n_hc;
                r_prev <= i_in_byte;
            end
            if (i_cmd.emit) begin
                r_ov   <= 1'b1;
                r_fill <= r_fill + 16'(keep_ok);
                r_ck   <= (emit_last && r_end) ? 16'd0 : ck_new;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_b        <= i_in_byte;
            r_end      <= i_chunk_end;
            r_ca       <= ca;
            r_srca_tag <= srca_tag;
            r_text     <= txt_keep;
            r_srcb_tag <= srcb_tag;
            r_offb     <= offb;
            r_total    <= total;
            r_empty    <= empty;
        end
        if (i_cmd.emit) begin
            r_obyte   <= keep_ok ? bsel : 8'h00;
            r_okept   <= keep_ok;
            r_ofull   <= !r_empty && !keep_ok;
            r_ocopied <= (emit_last && r_end) ? ck_new : 16'd0;
            r_olast   <= emit_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_byte     = r_obyte;
    assign o_out_kept     = r_okept;
    assign o_buffer_full  = r_ofull;
    assign o_chunk_copied = r_ocopied;
    assign o_last         = r_olast;

endmodule

// ===== sv/html_text_stripper.sv =====
// An item that causes results is registered into the result plan when accepted; its results
// go out through the output register. Throughput: one item per cycle when it causes at most
// one result and the output does not stall; with N results it holds the input, one result per
// cycle while the output accepts. The next item is accepted in the cycle its predecessor's last
// result is loaded. Reset: synchronous, active low; text mode, counters cleared, capacity 4096.
// The tag hold memory is not cleared.
module html_text_stripper #(
    parameter int TAG_HOLD = hts_pkg::TAG_HOLD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    hts_in_if.sink      i_in,
    hts_out_if.source   o_out
);

    hts_pkg::t_cmd cmd;
    hts_pkg::t_sts sts;
    logic          in_ready;

    hts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hts_dpath #(
        .TAG_HOLD (TAG_HOLD)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_byte      (i_in.in_byte),
        .i_chunk_end    (i_in.chunk_end),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_out_byte     (o_out.out_byte),
        .o_out_kept     (o_out.out_valid),
        .o_buffer_full  (o_out.buffer_full),
        .o_chunk_copied (o_out.chunk_copied),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule

// ===== sv/hts_checker.sv =====
// Port-level checks for the HTML text stripper, bound to the top level.
// Depends on html_text_stripper and its interfaces.
module hts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_out_kept,
    input logic        i_buffer_full,
    input logic [15:0] i_chunk_copied,
    input logic        i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_out_byte, i_out_kept, i_buffer_full, i_chunk_copied, i_last}))
        else $error("stalled item changed");

    a_kept_xor_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_kept && i_buffer_full) && (i_out_kept || i_out_byte == 8'h00))
        else $error("kept and lost flags disagree");

    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_chunk_copied != 16'd0) |-> i_last)
        else $error("chunk count on a non-final item");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_kept && !i_buffer_full |-> i_last && (i_out_byte == 8'h00))
        else $error("empty item not final");

endmodule

bind html_text_stripper hts_checker u_hts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_kept     (o_out.out_valid),
    .i_buffer_full  (o_out.buffer_full),
    .i_chunk_copied (o_out.chunk_copied),
    .i_last         (o_out.last)
);
